/* src/sidau_pkg.sv */
package sidau_pkg;

    // Width of the magnitude and of one character.
    localparam int MAG_W   = 32;
    localparam int CHAR_W  = 8;
    localparam int DIGIT_W = 4;

    // Reciprocal of ten: floor(n * RECIP_10 / 2**RECIP_SHIFT) equals n / 10
    // for every 32-bit n.
    localparam logic [MAG_W-1:0] RECIP_10    = 32'hCCCC_CCCD;
    localparam int               RECIP_SHIFT = 35;

    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;

    // One word travelling down the chain of digit cells.
    typedef struct packed {
        logic             valid;
        logic             neg;
        logic [MAG_W-1:0] mag;
    } t_lane;

endpackage

/* src/signed_int_to_decimal_ascii_unit.sv */
// Signed 32-bit integer to decimal ASCII text.
//
// A command beat is taken at a clock edge where i_start is high and o_busy
// is low; i_number is sampled on that edge. Each value comes out as a run
// of character beats on o_ascii_char, one per cycle, each marked by
// o_strobe for exactly one cycle: an optional '-' and then the decimal
// digits with leading zeros suppressed, a zero value giving a single '0'.
// o_last_char flags the final beat of every run.
//
// From the command beat to the first character a word passes the chain of
// DIGIT_COUNT digit cells, each of which splits off one decimal digit
// with a reciprocal multiply, then the serialiser load and the output
// register. Runs follow one another with no gap; a run holds 1 to
// DIGIT_COUNT + 1 characters, eleven at most for the default. o_busy is
// high whenever the last cell holds a word that the serialiser cannot
// take yet; the whole chain then holds, empty slots included.
//
// The receiver cannot stall; every strobed beat is final. A synchronous
// reset (i_rst_n low) drops all words in flight and clears the strobe.
module signed_int_to_decimal_ascii_unit
    import sidau_pkg::*;
#(
    parameter int DIGIT_COUNT = 10
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    output logic                     o_busy,
    input  logic signed [MAG_W-1:0]  i_number,
    output logic                     o_strobe,
    output logic [CHAR_W-1:0]        o_ascii_char,
    output logic                     o_last_char
);

    localparam int IDX_W = $clog2(DIGIT_COUNT);

    // Chain links: entry 0 is the command side, entry DIGIT_COUNT feeds the
    // serialiser.
    t_lane                              lane     [DIGIT_COUNT+1];
    logic [DIGIT_COUNT-1:0][DIGIT_W-1:0] digits   [DIGIT_COUNT+1];
    logic [IDX_W-1:0]                   top      [DIGIT_COUNT+1];

    logic             adv;
    logic             take;
    logic [MAG_W-1:0] raw;

    // The whole chain moves as one; it stops only when its last cell holds
    // a word that the serialiser cannot take yet.
    assign adv    = !lane[DIGIT_COUNT].valid || take;
    assign o_busy = !adv;

    // The magnitude is taken as unsigned, so the most negative value keeps
    // its full magnitude of 2**31.
    assign raw           = $unsigned(i_number);
    assign lane[0].valid = i_start && !o_busy;
    assign lane[0].neg   = raw[MAG_W-1];
    assign lane[0].mag   = raw[MAG_W-1] ? (MAG_W'(0) - raw) : raw;
    assign digits[0]     = '0;
    assign top[0]        = '0;

    for (genvar g = 0; g < DIGIT_COUNT; g++) begin : g_cell
        sidau_cell #(
            .DIGIT_COUNT (DIGIT_COUNT),
            .POS         (g),
            .IDX_W       (IDX_W)
        ) u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_adv    (adv),
            .i_lane   (lane[g]),
            .i_digits (digits[g]),
            .i_top    (top[g]),
            .o_lane   (lane[g+1]),
            .o_digits (digits[g+1]),
            .o_top    (top[g+1])
        );
    end

    // The serialiser walks from the top non-zero digit down to the units
    // digit, sending the sign first where there is one.
    sidau_serializer #(
        .DIGIT_COUNT (DIGIT_COUNT),
        .IDX_W       (IDX_W)
    ) u_ser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (lane[DIGIT_COUNT].valid),
        .i_neg    (lane[DIGIT_COUNT].neg),
        .i_digits (digits[DIGIT_COUNT]),
        .i_top    (top[DIGIT_COUNT]),
        .o_take   (take),
        .o_strobe (o_strobe),
        .o_char   (o_ascii_char),
        .o_last   (o_last_char)
    );

endmodule

/* src/sidau_cell.sv */
module sidau_cell
    import sidau_pkg::*;
#(
    parameter int DIGIT_COUNT = 10,
    parameter int POS         = 0,
    parameter int IDX_W       = 4
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_adv,
    input  t_lane                             i_lane,
    input  logic [DIGIT_COUNT-1:0][DIGIT_W-1:0] i_digits,
    input  logic [IDX_W-1:0]                  i_top,
    output t_lane                             o_lane,
    output logic [DIGIT_COUNT-1:0][DIGIT_W-1:0] o_digits,
    output logic [IDX_W-1:0]                  o_top
);

    logic [2*MAG_W-1:0]                 prod;
    logic [MAG_W-1:0]                   quot;
    logic [MAG_W-1:0]                   rem;
    logic [DIGIT_W-1:0]                 digit;
    logic [DIGIT_COUNT-1:0][DIGIT_W-1:0] n_digits;

    logic                               r_valid;
    logic                               r_neg;
    logic [MAG_W-1:0]                   r_mag;
    logic [DIGIT_COUNT-1:0][DIGIT_W-1:0] r_digits;
    logic [IDX_W-1:0]                   r_top;

    // Divide by ten through the reciprocal; the remainder is the digit.
    assign prod  = {{MAG_W{1'b0}}, i_lane.mag} * {{MAG_W{1'b0}}, RECIP_10};
    assign quot  = MAG_W'(prod >> RECIP_SHIFT);
    assign rem   = i_lane.mag - (quot << 3) - (quot << 1);
    assign digit = rem[DIGIT_W-1:0];

    always_comb begin
        n_digits      = i_digits;
        n_digits[POS] = digit;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_lane.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_neg    <= i_lane.neg;
            r_mag    <= quot;
            r_digits <= n_digits;
            r_top    <= (digit != '0) ? IDX_W'(POS) : i_top;
        end
    end

    assign o_lane.valid = r_valid;
    assign o_lane.neg   = r_neg;
    assign o_lane.mag   = r_mag;
    assign o_digits     = r_digits;
    assign o_top        = r_top;

endmodule

/* src/sidau_serializer.sv */
module sidau_serializer
    import sidau_pkg::*;
#(
    parameter int DIGIT_COUNT = 10,
    parameter int IDX_W       = 4
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    input  logic                              i_neg,
    input  logic [DIGIT_COUNT-1:0][DIGIT_W-1:0] i_digits,
    input  logic [IDX_W-1:0]                  i_top,
    output logic                              o_take,
    output logic                              o_strobe,
    output logic [CHAR_W-1:0]                 o_char,
    output logic                              o_last
);

    logic                               r_active;
    logic                               r_sign;
    logic [IDX_W-1:0]                   r_pos;
    logic [DIGIT_COUNT-1:0][DIGIT_W-1:0] r_digits;
    logic                               r_strobe;
    logic [CHAR_W-1:0]                  r_char;
    logic                               r_last;

    logic                               done;
    logic [CHAR_W-1:0]                  n_char;
    logic                               n_last;

    // The word finishes when its units digit goes out.
    assign done   = r_active && !r_sign && (r_pos == '0);
    assign o_take = i_valid && (!r_active || done);

    always_comb begin
        n_char = r_sign ? CHAR_MINUS
                        : CHAR_ZERO + {{(CHAR_W-DIGIT_W){1'b0}}, r_digits[r_pos]};
        n_last = !r_sign && (r_pos == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_sign   <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= r_active;
            if (o_take) begin
                r_active <= 1'b1;
                r_sign   <= i_neg;
            end else if (r_active) begin
                if (r_sign) begin
                    r_sign <= 1'b0;
                end else if (r_pos == '0) begin
                    r_active <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_pos    <= i_top;
            r_digits <= i_digits;
        end else if (r_active && !r_sign && (r_pos != '0)) begin
            r_pos <= r_pos - IDX_W'(1);
        end
        r_char <= n_char;
        r_last <= n_last;
    end

    assign o_strobe = r_strobe;
    assign o_char   = r_char;
    assign o_last   = r_last;

endmodule

/* src/sidau_checker.sv */
module sidau_checker
    import sidau_pkg::*;
(
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    i_start,
    input logic                    o_busy,
    input logic signed [MAG_W-1:0] i_number,
    input logic                    o_strobe,
    input logic [CHAR_W-1:0]       o_ascii_char,
    input logic                    o_last_char
);

    // Every character beat is a sign or a decimal digit.
    a_char_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_ascii_char == CHAR_MINUS) ||
                     ((o_ascii_char >= CHAR_ZERO) && (o_ascii_char <= CHAR_ZERO + 8'd9)))
        else $error("character beat outside sign and digits");

    // The sign never ends a run.
    a_sign_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && (o_ascii_char == CHAR_MINUS)) |-> !o_last_char)
        else $error("sign flagged as last character");

    // A run never breaks off before its flagged last beat.
    a_run_gapless: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_last_char) |=> o_strobe)
        else $error("gap inside a character run");

    // The beat after a sign is a digit.
    a_digit_after_sign: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && (o_ascii_char == CHAR_MINUS)) |=>
        (o_strobe && (o_ascii_char != CHAR_MINUS)))
        else $error("sign not followed by a digit");

    // A zero that is not the units digit cannot lead the number.
    a_no_leading_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && (o_ascii_char == CHAR_ZERO) && !o_last_char) |->
        $past(o_strobe && !o_last_char && (o_ascii_char != CHAR_MINUS)))
        else $error("leading zero sent");

endmodule

bind signed_int_to_decimal_ascii_unit sidau_checker u_chk (.*);
